@@ design/stm_pkg.sv @@
// stm_pkg: shared types, constants and helpers for the SAD template matcher.
// No dependencies; compiled first.
package stm_pkg;

   localparam int IMAGE_MAX_ROWS_DEF    = 64;
   localparam int IMAGE_MAX_COLS_DEF    = 64;
   localparam int TEMPLATE_MAX_ROWS_DEF = 16;
   localparam int TEMPLATE_MAX_COLS_DEF = 16;

   localparam int OP_W     = 2;
   localparam int COORD_W  = 6;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int PSAD_W   = 10;            // one pixel: up to 3*255
   localparam int SAD_W    = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int IMG_SIZE_W = 7;
   localparam int TPL_SIZE_W = 5;

   localparam logic [SAD_W-1:0] SAD_MAX = '1;

   localparam logic [IMG_SIZE_W-1:0] IMG_SIZE_RST = 7'd64;
   localparam logic [TPL_SIZE_W-1:0] TPL_SIZE_RST = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_WR_IMAGE    = 2'd0,
      OP_WR_TEMPLATE = 2'd1,
      OP_SEARCH      = 2'd2
   } stm_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_HEIGHT    = 2'd0,
      CSR_IMAGE_WIDTH     = 2'd1,
      CSR_TEMPLATE_HEIGHT = 2'd2,
      CSR_TEMPLATE_WIDTH  = 2'd3
   } stm_csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } stm_state_type;

   // per-beat tag that rides along with a pixel pair
   typedef struct packed {
      logic valid;
      logic first;   // first pixel of a placement
      logic last;    // last pixel of a placement
   } stm_tag_type;

   // size register value 0 is taken as 1, anything above the max as the max
   function automatic int clamp_size(int v, int hi);
      int r;
      r = v;
      if (r < 1) r = 1;
      if (r > hi) r = hi;
      return r;
   endfunction

endpackage

@@ design/stm_ifs.sv @@
// stm_ifs: request and response channel interfaces of the template matcher.
// Depends on stm_pkg for field widths.
interface stm_req_if import stm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [COORD_W-1:0]  row;
   logic [COORD_W-1:0]  col;
   logic [CHAN_W-1:0]   red;
   logic [CHAN_W-1:0]   green;
   logic [CHAN_W-1:0]   blue;

   modport source (output valid, operation, row, col, red, green, blue, input ready);
   modport sink   (input valid, operation, row, col, red, green, blue, output ready);
endinterface

interface stm_rsp_if import stm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  best_row;
   logic [COORD_W-1:0]  best_col;
   logic [SAD_W-1:0]    best_sad;
   logic                found;

   modport source (output valid, best_row, best_col, best_sad, found, input ready);
   modport sink   (input valid, best_row, best_col, best_sad, found, output ready);
endinterface

@@ design/stm_sad_unit.sv @@
// stm_sad_unit: shared absolute-difference / accumulate / minimum datapath.
// Takes one image and one template pixel per beat. Depends on stm_pkg.
module stm_sad_unit import stm_pkg::*; #(
   parameter int ROW_W = 6,
   parameter int COL_W = 6,
   parameter int ACC_W = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  stm_tag_type       in_tag,
   input  logic [ROW_W-1:0]  in_row,
   input  logic [COL_W-1:0]  in_col,
   input  logic [PIX_W-1:0]  img_pix,
   input  logic [PIX_W-1:0]  tpl_pix,
   output logic              busy,
   output logic [SAD_W-1:0]  min_sum,
   output logic [ROW_W-1:0]  min_row,
   output logic [COL_W-1:0]  min_col
);

   stm_tag_type        tag_b_ff;
   logic [PSAD_W-1:0]  psad_ff, psad_in;
   logic [ROW_W-1:0]   row_b_ff, row_c_ff;
   logic [COL_W-1:0]   col_b_ff, col_c_ff;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               done_c_ff;
   logic               have_ff;
   logic [SAD_W-1:0]   min_sum_ff;
   logic [ROW_W-1:0]   min_row_ff;
   logic [COL_W-1:0]   min_col_ff;
   logic [SAD_W-1:0]   sat_sum;
   logic               take;

   function automatic logic [CHAN_W:0] absdiff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
   endfunction

   // stage B: per-pixel SAD
   always_comb begin
      psad_in = PSAD_W'(absdiff(img_pix[23:16], tpl_pix[23:16]))
              + PSAD_W'(absdiff(img_pix[15:8],  tpl_pix[15:8]))
              + PSAD_W'(absdiff(img_pix[7:0],   tpl_pix[7:0]));
   end

   // stage C: accumulate over the placement
   always_comb begin
      acc_in = (tag_b_ff.first ? '0 : acc_ff) + ACC_W'(psad_ff);
   end

   // stage D: saturate and compare against the running best
   always_comb begin
      if (acc_ff > ACC_W'(SAD_MAX)) begin
         sat_sum = SAD_MAX;
      end else begin
         sat_sum = SAD_W'(acc_ff);
      end
      take = done_c_ff && (!have_ff || (sat_sum < min_sum_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff  <= '0;
         done_c_ff <= 1'b0;
      end else begin
         tag_b_ff  <= in_tag;
         done_c_ff <= tag_b_ff.valid && tag_b_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      psad_ff  <= psad_in;
      row_b_ff <= in_row;
      col_b_ff <= in_col;
      row_c_ff <= row_b_ff;
      col_c_ff <= col_b_ff;
      if (tag_b_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have_ff    <= 1'b0;
         min_sum_ff <= SAD_MAX;
         min_row_ff <= '0;
         min_col_ff <= '0;
      end else if (take) begin
         have_ff    <= 1'b1;
         min_sum_ff <= sat_sum;
         min_row_ff <= row_c_ff;
         min_col_ff <= col_c_ff;
      end
   end

   assign busy    = tag_b_ff.valid || done_c_ff;
   assign min_sum = min_sum_ff;
   assign min_row = min_row_ff;
   assign min_col = min_col_ff;

endmodule

@@ design/sad_template_match.sv @@
// sad_template_match: top level - size registers, pixel stores, placement sequencer.
// Depends on stm_pkg, stm_ifs (stm_req_if, stm_rsp_if) and stm_sad_unit.
//
//   channel   kind        beat contents
//   req_chan  sink        operation, row, col, red, green, blue
//   rsp_chan  source      best_row, best_col, best_sad, found (one per search)
//   csr_*     write only  csr_we, csr_index, csr_wdata
//
// Pixel writes and unused operations are accepted while idle; beats can arrive back to back.
// A search streams one pixel pair per cycle through the single SAD unit
// fed by one read port on each store.
// req_chan.ready is low while a search runs; a pending result waits in its own register.
// Reset is synchronous; pixel stores are not cleared and hold nothing until written.
module sad_template_match import stm_pkg::*; #(
   parameter int IMAGE_MAX_ROWS    = IMAGE_MAX_ROWS_DEF,
   parameter int IMAGE_MAX_COLS    = IMAGE_MAX_COLS_DEF,
   parameter int TEMPLATE_MAX_ROWS = TEMPLATE_MAX_ROWS_DEF,
   parameter int TEMPLATE_MAX_COLS = TEMPLATE_MAX_COLS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   stm_req_if.sink                req_chan,
   stm_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IMG_DEPTH = IMAGE_MAX_ROWS * IMAGE_MAX_COLS;
   localparam int TPL_DEPTH = TEMPLATE_MAX_ROWS * TEMPLATE_MAX_COLS;
   localparam int IR_W  = $clog2(IMAGE_MAX_ROWS);
   localparam int IC_W  = $clog2(IMAGE_MAX_COLS);
   localparam int TR_W  = (TEMPLATE_MAX_ROWS > 1) ? $clog2(TEMPLATE_MAX_ROWS) : 1;
   localparam int TC_W  = (TEMPLATE_MAX_COLS > 1) ? $clog2(TEMPLATE_MAX_COLS) : 1;
   localparam int IA_W  = $clog2(IMG_DEPTH);
   localparam int TA_W  = (TPL_DEPTH > 1) ? $clog2(TPL_DEPTH) : 1;
   localparam int ACC_W = $clog2(TPL_DEPTH * 765 + 1);

   // size registers
   logic [IMG_SIZE_W-1:0] img_h_ff, img_w_ff;
   logic [TPL_SIZE_W-1:0] tpl_h_ff, tpl_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_h_ff <= IMG_SIZE_RST;
         img_w_ff <= IMG_SIZE_RST;
         tpl_h_ff <= TPL_SIZE_RST;
         tpl_w_ff <= TPL_SIZE_RST;
      end else if (csr_we) begin
         unique case (stm_csr_type'(csr_index))
            CSR_IMAGE_HEIGHT:    img_h_ff <= csr_wdata;
            CSR_IMAGE_WIDTH:     img_w_ff <= csr_wdata;
            CSR_TEMPLATE_HEIGHT: tpl_h_ff <= TPL_SIZE_W'(csr_wdata);
            CSR_TEMPLATE_WIDTH:  tpl_w_ff <= TPL_SIZE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   // clamped sizes, used when a search starts
   int  ih, iw, th, tw;
   logic fit_now;

   always_comb begin
      ih = clamp_size(int'(img_h_ff), IMAGE_MAX_ROWS);
      iw = clamp_size(int'(img_w_ff), IMAGE_MAX_COLS);
      th = clamp_size(int'(tpl_h_ff), TEMPLATE_MAX_ROWS);
      tw = clamp_size(int'(tpl_w_ff), TEMPLATE_MAX_COLS);
      fit_now = (th <= ih) && (tw <= iw);
   end

   // sequencer state
   stm_state_type      state_ff, state_in;
   logic [IR_W-1:0]    rlim_ff, r_ff, r_in;
   logic [IC_W-1:0]    clim_ff, c_ff, c_in;
   logic [TR_W-1:0]    thm1_ff, y_ff, y_in;
   logic [TC_W-1:0]    twm1_ff, x_ff, x_in;
   logic               fit_ff;

   logic               req_fire, start, issue, pix_last, place_last, all_last;
   logic               rsp_load, unit_clear;
   stm_tag_type        rd_tag_ff, rd_tag_in;
   logic [IR_W-1:0]    rd_r_ff;
   logic [IC_W-1:0]    rd_c_ff;

   // stores
   logic [PIX_W-1:0]   img_mem [IMG_DEPTH];
   logic [PIX_W-1:0]   tpl_mem [TPL_DEPTH];
   logic [PIX_W-1:0]   img_q_ff, tpl_q_ff;
   logic [IA_W-1:0]    img_waddr, img_raddr;
   logic [TA_W-1:0]    tpl_waddr, tpl_raddr;
   logic [PIX_W-1:0]   wr_pix;
   logic               img_we, tpl_we;

   // results
   logic               unit_busy;
   logic [SAD_W-1:0]   min_sum;
   logic [IR_W-1:0]    min_row;
   logic [IC_W-1:0]    min_col;
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] best_row_ff, best_col_ff;
   logic [SAD_W-1:0]   best_sad_ff;
   logic               found_ff;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign start          = req_fire && (req_chan.operation == OP_SEARCH);
   assign unit_clear     = start;

   // pixel write and store read addresses
   always_comb begin
      wr_pix    = {req_chan.red, req_chan.green, req_chan.blue};
      img_waddr = IA_W'(int'(req_chan.row) * IMAGE_MAX_COLS + int'(req_chan.col));
      tpl_waddr = TA_W'(int'(req_chan.row) * TEMPLATE_MAX_COLS + int'(req_chan.col));
      img_we    = req_fire && (req_chan.operation == OP_WR_IMAGE)
                  && (int'(req_chan.row) < IMAGE_MAX_ROWS)
                  && (int'(req_chan.col) < IMAGE_MAX_COLS);
      tpl_we    = req_fire && (req_chan.operation == OP_WR_TEMPLATE)
                  && (int'(req_chan.row) < TEMPLATE_MAX_ROWS)
                  && (int'(req_chan.col) < TEMPLATE_MAX_COLS);
      img_raddr = IA_W'((int'(r_ff) + int'(y_ff)) * IMAGE_MAX_COLS
                        + int'(c_ff) + int'(x_ff));
      tpl_raddr = TA_W'(int'(y_ff) * TEMPLATE_MAX_COLS + int'(x_ff));
   end

   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= wr_pix;
      end
      img_q_ff <= img_mem[img_raddr];
   end

   always_ff @(posedge clock) begin
      if (tpl_we) begin
         tpl_mem[tpl_waddr] <= wr_pix;
      end
      tpl_q_ff <= tpl_mem[tpl_raddr];
   end

   // placement walk: x fastest, then y, then c, then r
   always_comb begin
      state_in   = state_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      y_in       = y_ff;
      x_in       = x_ff;
      issue      = 1'b0;
      rsp_load   = 1'b0;
      pix_last   = (x_ff == twm1_ff) && (y_ff == thm1_ff);
      place_last = (c_ff == clim_ff);
      all_last   = pix_last && place_last && (r_ff == rlim_ff);
      rd_tag_in.valid = 1'b0;
      rd_tag_in.first = (x_ff == '0) && (y_ff == '0);
      rd_tag_in.last  = pix_last;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               r_in = '0;
               c_in = '0;
               y_in = '0;
               x_in = '0;
               state_in = fit_now ? ST_RUN : ST_FINISH;
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            rd_tag_in.valid = 1'b1;
            if (x_ff != twm1_ff) begin
               x_in = x_ff + 1'b1;
            end else begin
               x_in = '0;
               if (y_ff != thm1_ff) begin
                  y_in = y_ff + 1'b1;
               end else begin
                  y_in = '0;
                  if (!place_last) begin
                     c_in = c_ff + 1'b1;
                  end else begin
                     c_in = '0;
                     r_in = r_ff + 1'b1;
                  end
               end
            end
            if (all_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_tag_ff.valid && !unit_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_tag_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_tag_ff <= rd_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      c_ff <= c_in;
      y_ff <= y_in;
      x_ff <= x_in;
      if (issue) begin
         rd_r_ff <= r_ff;
         rd_c_ff <= c_ff;
      end
      if (start) begin
         fit_ff  <= fit_now;
         rlim_ff <= IR_W'(ih - th);
         clim_ff <= IC_W'(iw - tw);
         thm1_ff <= TR_W'(th - 1);
         twm1_ff <= TC_W'(tw - 1);
      end
   end

   stm_sad_unit #(
      .ROW_W (IR_W),
      .COL_W (IC_W),
      .ACC_W (ACC_W)
   ) u_sad (
      .clock   (clock),
      .reset   (reset),
      .clear   (unit_clear),
      .in_tag  (rd_tag_ff),
      .in_row  (rd_r_ff),
      .in_col  (rd_c_ff),
      .img_pix (img_q_ff),
      .tpl_pix (tpl_q_ff),
      .busy    (unit_busy),
      .min_sum (min_sum),
      .min_row (min_row),
      .min_col (min_col)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         found_ff    <= fit_ff;
         best_row_ff <= fit_ff ? COORD_W'(min_row) : '0;
         best_col_ff <= fit_ff ? COORD_W'(min_col) : '0;
         best_sad_ff <= fit_ff ? min_sum : '0;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.best_row = best_row_ff;
   assign rsp_chan.best_col = best_col_ff;
   assign rsp_chan.best_sad = best_sad_ff;
   assign rsp_chan.found    = found_ff;

endmodule
